// ===== rtl/gripper_pulse_sequencer_core_defines.svh =====
// Assertion macros for the gripper pulse sequencer.
`ifndef GRIPPER_PULSE_SEQUENCER_CORE_DEFINES_SVH
`define GRIPPER_PULSE_SEQUENCER_CORE_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define GPS_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("gps assertion failed");
`define GPS_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("gps assertion failed");
`else
`define GPS_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define GPS_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif

`endif

// ===== rtl/gps_pkg.sv =====
// Package: types and constants of the gripper pulse sequencer.
`default_nettype none
package gps_pkg;

  localparam int GPS_COUNT_BITS = 16;
  localparam int GPS_POS_W      = 17;
  localparam int GPS_TICKS_W    = 16;
  localparam int GPS_PHASE_W    = 2;
  localparam int GPS_CFG_IDX_W  = 3;

  localparam logic [GPS_POS_W-1:0]   GPS_OPEN_POS_RST  = GPS_POS_W'(22200);
  localparam logic [GPS_POS_W-1:0]   GPS_CLOSE_POS_RST = GPS_POS_W'(21000);
  localparam logic [GPS_TICKS_W-1:0] GPS_HOLD_RST      = GPS_TICKS_W'(50);
  localparam logic [GPS_TICKS_W-1:0] GPS_TIMEOUT_RST   = GPS_TICKS_W'(500);

  localparam logic [GPS_CFG_IDX_W-1:0] GPS_REG_OPEN_POS  = GPS_CFG_IDX_W'(0);
  localparam logic [GPS_CFG_IDX_W-1:0] GPS_REG_CLOSE_POS = GPS_CFG_IDX_W'(1);
  localparam logic [GPS_CFG_IDX_W-1:0] GPS_REG_HOLD      = GPS_CFG_IDX_W'(2);
  localparam logic [GPS_CFG_IDX_W-1:0] GPS_REG_TIMEOUT   = GPS_CFG_IDX_W'(3);

  localparam logic [GPS_PHASE_W-1:0] GPS_PHASE_IDLE  = 2'd0;
  localparam logic [GPS_PHASE_W-1:0] GPS_PHASE_OPEN  = 2'd1;
  localparam logic [GPS_PHASE_W-1:0] GPS_PHASE_HOLD  = 2'd2;
  localparam logic [GPS_PHASE_W-1:0] GPS_PHASE_CLOSE = 2'd3;

  typedef struct packed {
    logic [GPS_POS_W-1:0]   open_target;
    logic [GPS_POS_W-1:0]   close_target;
    logic [GPS_TICKS_W-1:0] hold_ticks;
    logic [GPS_TICKS_W-1:0] timeout_ticks;
  } gps_cfg_t;

  typedef struct packed {
    logic trigger;
    logic moving;
    logic at_target;
    logic obj_stop;
  } gps_tick_t;

  typedef struct packed {
    logic                   issue_move;
    logic [GPS_POS_W-1:0]   move_position_um;
    logic [GPS_PHASE_W-1:0] phase_now;
    logic                   report_valid;
    logic                   open_motion_seen;
    logic [GPS_TICKS_W-1:0] open_motion_ticks;
    logic [GPS_TICKS_W-1:0] open_reach_ticks;
    logic                   open_timed_out;
    logic                   close_motion_seen;
    logic [GPS_TICKS_W-1:0] close_motion_ticks;
    logic [GPS_TICKS_W-1:0] close_reach_ticks;
    logic                   close_timed_out;
  } gps_result_t;

endpackage
`default_nettype wire

// ===== rtl/gps_seq.sv =====
// Phase sequencer: pulse state, counters, latches and the result register.
`default_nettype none
module gps_seq #(
  parameter int COUNT_BITS = gps_pkg::GPS_COUNT_BITS
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                take_i,
  input  wire gps_pkg::gps_tick_t  tick_i,
  input  wire gps_pkg::gps_cfg_t   cfg_i,
  input  wire logic                drain_i,
  output logic                     out_valid_o,
  output gps_pkg::gps_result_t     res_o
);
  import gps_pkg::*;

  localparam int CMP_W = (COUNT_BITS > GPS_TICKS_W) ? COUNT_BITS : GPS_TICKS_W;

  typedef enum logic [GPS_PHASE_W-1:0] {
    ST_IDLE  = GPS_PHASE_IDLE,
    ST_OPEN  = GPS_PHASE_OPEN,
    ST_HOLD  = GPS_PHASE_HOLD,
    ST_CLOSE = GPS_PHASE_CLOSE
  } state_t;

  state_t                 phase_r, phase_nxt;
  logic [COUNT_BITS-1:0]  cnt_r, cnt_nxt, cnt_inc;
  logic                   open_seen_r, open_seen_nxt;
  logic                   open_to_r, open_to_nxt;
  logic                   close_seen_r, close_seen_nxt;
  logic [GPS_TICKS_W-1:0] open_motion_r, open_motion_nxt;
  logic [GPS_TICKS_W-1:0] open_reach_r, open_reach_nxt;
  logic [GPS_TICKS_W-1:0] close_motion_r, close_motion_nxt;
  logic [GPS_POS_W-1:0]   snap_close_r, snap_close_nxt;
  logic [GPS_TICKS_W-1:0] snap_hold_r, snap_hold_nxt;
  logic                   out_valid_r;
  gps_result_t            res_r, res_nxt;

  logic                   done;
  logic                   timed_out;
  logic                   hold_done;
  logic [GPS_TICKS_W-1:0] cnt_lat;

  assign cnt_inc   = (cnt_r == {COUNT_BITS{1'b1}}) ? cnt_r : cnt_r + COUNT_BITS'(1);
  assign done      = tick_i.at_target | tick_i.obj_stop;
  assign timed_out = CMP_W'(cnt_inc) > CMP_W'(cfg_i.timeout_ticks);
  assign hold_done = CMP_W'(cnt_inc) >= CMP_W'(snap_hold_r);
  assign cnt_lat   = GPS_TICKS_W'(cnt_inc);

  always_comb begin
    phase_nxt        = phase_r;
    cnt_nxt          = cnt_r;
    open_seen_nxt    = open_seen_r;
    open_to_nxt      = open_to_r;
    close_seen_nxt   = close_seen_r;
    open_motion_nxt  = open_motion_r;
    open_reach_nxt   = open_reach_r;
    close_motion_nxt = close_motion_r;
    snap_close_nxt   = snap_close_r;
    snap_hold_nxt    = snap_hold_r;
    res_nxt          = '0;
    unique case (phase_r)
      ST_IDLE: begin
        if (tick_i.trigger) begin
          res_nxt.issue_move       = 1'b1;
          res_nxt.move_position_um = cfg_i.open_target;
          snap_close_nxt           = cfg_i.close_target;
          snap_hold_nxt            = cfg_i.hold_ticks;
          cnt_nxt                  = '0;
          open_seen_nxt            = 1'b0;
          open_to_nxt              = 1'b0;
          close_seen_nxt           = 1'b0;
          open_motion_nxt          = '0;
          open_reach_nxt           = '0;
          close_motion_nxt         = '0;
          phase_nxt                = ST_OPEN;
        end
      end
      ST_OPEN: begin
        cnt_nxt = cnt_inc;
        if (!open_seen_r && tick_i.moving) begin
          open_seen_nxt   = 1'b1;
          open_motion_nxt = cnt_lat;
        end
        if (done || timed_out) begin
          open_reach_nxt = cnt_lat;
          open_to_nxt    = !done;
          cnt_nxt        = '0;
          phase_nxt      = ST_HOLD;
        end
      end
      ST_HOLD: begin
        cnt_nxt = cnt_inc;
        if (hold_done) begin
          res_nxt.issue_move       = 1'b1;
          res_nxt.move_position_um = snap_close_r;
          cnt_nxt                  = '0;
          phase_nxt                = ST_CLOSE;
        end
      end
      ST_CLOSE: begin
        cnt_nxt = cnt_inc;
        if (!close_seen_r && tick_i.moving) begin
          close_seen_nxt   = 1'b1;
          close_motion_nxt = cnt_lat;
        end
        if (done || timed_out) begin
          res_nxt.report_valid       = 1'b1;
          res_nxt.open_motion_seen   = open_seen_r;
          res_nxt.open_motion_ticks  = open_motion_r;
          res_nxt.open_reach_ticks   = open_reach_r;
          res_nxt.open_timed_out     = open_to_r;
          res_nxt.close_motion_seen  = close_seen_nxt;
          res_nxt.close_motion_ticks = close_motion_nxt;
          res_nxt.close_reach_ticks  = cnt_lat;
          res_nxt.close_timed_out    = !done;
          cnt_nxt                    = '0;
          phase_nxt                  = ST_IDLE;
        end
      end
    endcase
    res_nxt.phase_now = phase_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r        <= ST_IDLE;
      cnt_r          <= '0;
      open_seen_r    <= 1'b0;
      open_to_r      <= 1'b0;
      close_seen_r   <= 1'b0;
      open_motion_r  <= '0;
      open_reach_r   <= '0;
      close_motion_r <= '0;
      snap_close_r   <= '0;
      snap_hold_r    <= '0;
      out_valid_r    <= 1'b0;
    end else begin
      if (take_i) begin
        phase_r        <= phase_nxt;
        cnt_r          <= cnt_nxt;
        open_seen_r    <= open_seen_nxt;
        open_to_r      <= open_to_nxt;
        close_seen_r   <= close_seen_nxt;
        open_motion_r  <= open_motion_nxt;
        open_reach_r   <= open_reach_nxt;
        close_motion_r <= close_motion_nxt;
        snap_close_r   <= snap_close_nxt;
        snap_hold_r    <= snap_hold_nxt;
        out_valid_r    <= 1'b1;
      end else if (drain_i) begin
        out_valid_r <= 1'b0;
      end
    end
    if (take_i) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid_o = out_valid_r;
  assign res_o       = res_r;

endmodule
`default_nettype wire

// ===== rtl/gripper_pulse_sequencer_core.sv =====
// Gripper pulse sequencer: top level with configuration registers and handshake.
//
// One input item is one status poll tick (trigger and the status bits for
// motion, position reached and object stop). Each item yields exactly one
// result item: the move command of that tick, the phase after it, and on
// the tick the pulse completes a latency report (report_valid with open
// and close figures).
// Latency: the result is valid in the cycle after the item is accepted.
// Throughput: one item per cycle; the whole phase update is one pass of
// logic into the result register.
// Stall: in_ready is high while the result register is empty or is being
// taken this cycle; while out_ready stays low the result holds and no new
// item is taken.
// Configuration: cfg_we writes register cfg_index (0 open position,
// 1 close position, 2 hold ticks, 3 timeout ticks) at once; other indexes
// are dropped. Close position and hold ticks are captured at the trigger.
// Reset (rst_n low, synchronous): registers return to defaults, phase
// goes idle, counters and latches clear, the result register empties.
`default_nettype none
`include "gripper_pulse_sequencer_core_defines.svh"
module gripper_pulse_sequencer_core #(
  parameter int COUNT_BITS = gps_pkg::GPS_COUNT_BITS
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               cfg_we,
  input  wire logic [gps_pkg::GPS_CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [gps_pkg::GPS_POS_W-1:0]      cfg_wdata,
  input  wire logic                               in_valid,
  output logic                                    in_ready,
  input  wire logic                               in_trigger,
  input  wire logic                               in_moving,
  input  wire logic                               in_at_position,
  input  wire logic                               in_object_detected,
  output logic                                    out_valid,
  input  wire logic                               out_ready,
  output logic                                    out_issue_move,
  output logic [gps_pkg::GPS_POS_W-1:0]           out_move_position_um,
  output logic [gps_pkg::GPS_PHASE_W-1:0]         out_phase_now,
  output logic                                    out_report_valid,
  output logic                                    out_open_motion_seen,
  output logic [gps_pkg::GPS_TICKS_W-1:0]         out_open_motion_ticks,
  output logic [gps_pkg::GPS_TICKS_W-1:0]         out_open_reach_ticks,
  output logic                                    out_open_timed_out,
  output logic                                    out_close_motion_seen,
  output logic [gps_pkg::GPS_TICKS_W-1:0]         out_close_motion_ticks,
  output logic [gps_pkg::GPS_TICKS_W-1:0]         out_close_reach_ticks,
  output logic                                    out_close_timed_out
);
  import gps_pkg::*;

  gps_cfg_t    cfg_r;
  gps_tick_t   tick;
  gps_result_t res;
  logic        take;
  logic        out_idle;
  logic        out_moving;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.open_target   <= GPS_OPEN_POS_RST;
      cfg_r.close_target  <= GPS_CLOSE_POS_RST;
      cfg_r.hold_ticks    <= GPS_HOLD_RST;
      cfg_r.timeout_ticks <= GPS_TIMEOUT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        GPS_REG_OPEN_POS:  cfg_r.open_target   <= cfg_wdata;
        GPS_REG_CLOSE_POS: cfg_r.close_target  <= cfg_wdata;
        GPS_REG_HOLD:      cfg_r.hold_ticks    <= GPS_TICKS_W'(cfg_wdata);
        GPS_REG_TIMEOUT:   cfg_r.timeout_ticks <= GPS_TICKS_W'(cfg_wdata);
        default: ;
      endcase
    end
  end

  assign in_ready = !out_valid || out_ready;
  assign take     = in_valid && in_ready;

  assign tick.trigger   = in_trigger;
  assign tick.moving    = in_moving;
  assign tick.at_target = in_at_position;
  assign tick.obj_stop  = in_object_detected;

  gps_seq #(
    .COUNT_BITS (COUNT_BITS)
  ) u_seq (
    .clk         (clk),
    .rst_n       (rst_n),
    .take_i      (take),
    .tick_i      (tick),
    .cfg_i       (cfg_r),
    .drain_i     (out_ready),
    .out_valid_o (out_valid),
    .res_o       (res)
  );

  assign out_issue_move         = res.issue_move;
  assign out_move_position_um   = res.move_position_um;
  assign out_phase_now          = res.phase_now;
  assign out_report_valid       = res.report_valid;
  assign out_open_motion_seen   = res.open_motion_seen;
  assign out_open_motion_ticks  = res.open_motion_ticks;
  assign out_open_reach_ticks   = res.open_reach_ticks;
  assign out_open_timed_out     = res.open_timed_out;
  assign out_close_motion_seen  = res.close_motion_seen;
  assign out_close_motion_ticks = res.close_motion_ticks;
  assign out_close_reach_ticks  = res.close_reach_ticks;
  assign out_close_timed_out    = res.close_timed_out;

  assign out_idle   = (out_phase_now == GPS_PHASE_IDLE);
  assign out_moving = (out_phase_now == GPS_PHASE_OPEN) || (out_phase_now == GPS_PHASE_CLOSE);

  `GPS_ASSERT_NEXT(a_take_fills, clk, rst_n, take, out_valid)
  `GPS_ASSERT_IMP(a_report_idle, clk, rst_n, out_valid && out_report_valid, out_idle)
  `GPS_ASSERT_IMP(a_move_phase, clk, rst_n, out_valid && out_issue_move, out_moving)
  `GPS_ASSERT_IMP(a_idle_pos_zero, clk, rst_n, out_valid && !out_issue_move, out_move_position_um == '0)

endmodule
`default_nettype wire

// ===== tb/sv/gripper_pulse_sequencer_core_test.sv =====
// Self-checking testbench for the gripper pulse sequencer core.
module gripper_pulse_sequencer_core_test;
  timeunit 1ns;
  timeprecision 1ps;
  import gps_pkg::*;

  localparam int CLK_PERIOD   = 8;
  localparam int LIMIT_CYCLES = 1_200_000;
  localparam int LONG_STALL   = 40;
  localparam int LONG_HOLD    = 20;
  localparam int MAX_PRINTS   = 40;
  localparam logic [GPS_CFG_IDX_W-1:0] REG_UNUSED_FIRST = GPS_CFG_IDX_W'(4);
  localparam logic [GPS_CFG_IDX_W-1:0] REG_UNUSED_LAST  = '1;
  localparam logic [GPS_POS_W-1:0]     POS_MAX          = GPS_POS_W'(85000);
  localparam logic [GPS_TICKS_W-1:0]   TICKS_MAX        = '1;

  class pulse_tracker;
    logic [GPS_POS_W-1:0]   open_target, close_target, snap_close;
    logic [GPS_TICKS_W-1:0] hold_len, timeout_len, snap_hold, count;
    logic [GPS_PHASE_W-1:0] phase;
    logic                   open_seen, open_to, close_seen;
    logic [GPS_TICKS_W-1:0] open_motion, open_reach, close_motion;
    gps_result_t            expected_outcomes[$];
    int                     fails;
    int                     outcomes_seen;

    function new();
      open_target  = GPS_OPEN_POS_RST;
      close_target = GPS_CLOSE_POS_RST;
      hold_len     = GPS_HOLD_RST;
      timeout_len  = GPS_TIMEOUT_RST;
      snap_close   = '0;
      snap_hold    = '0;
      count        = '0;
      phase        = GPS_PHASE_IDLE;
      open_seen    = 1'b0;
      open_to      = 1'b0;
      close_seen   = 1'b0;
      open_motion  = '0;
      open_reach   = '0;
      close_motion = '0;
      fails        = 0;
      outcomes_seen = 0;
    endfunction

    function void write_reg(logic [GPS_CFG_IDX_W-1:0] idx, logic [GPS_POS_W-1:0] data);
      case (idx)
        GPS_REG_OPEN_POS:  open_target = data;
        GPS_REG_CLOSE_POS: close_target = data;
        GPS_REG_HOLD:      hold_len = data[GPS_TICKS_W-1:0];
        GPS_REG_TIMEOUT:   timeout_len = data[GPS_TICKS_W-1:0];
        default: ;
      endcase
    endfunction

    function void bump_count();
      if (count != TICKS_MAX) count = count + 1'b1;
    endfunction

    // one poll tick accepted: advance the sequencer and queue its outcome
    function void advance_pulse(gps_tick_t t);
      gps_result_t            r;
      logic                   done;
      logic                   finished;
      logic [GPS_TICKS_W-1:0] close_reach;
      logic                   close_to;
      r = '0;
      finished = 1'b0;
      close_reach = '0;
      close_to = 1'b0;
      done = t.at_target | t.obj_stop;
      case (phase)
        GPS_PHASE_IDLE: begin
          if (t.trigger) begin
            r.issue_move = 1'b1;
            r.move_position_um = open_target;
            snap_close = close_target;
            snap_hold = hold_len;
            count = '0;
            open_seen = 1'b0;
            open_to = 1'b0;
            close_seen = 1'b0;
            open_motion = '0;
            open_reach = '0;
            close_motion = '0;
            phase = GPS_PHASE_OPEN;
          end
        end
        GPS_PHASE_OPEN: begin
          bump_count();
          if (!open_seen && t.moving) begin
            open_seen = 1'b1;
            open_motion = count;
          end
          if (done || count > timeout_len) begin
            open_reach = count;
            open_to = !done;
            count = '0;
            phase = GPS_PHASE_HOLD;
          end
        end
        GPS_PHASE_HOLD: begin
          bump_count();
          if (count >= snap_hold) begin
            r.issue_move = 1'b1;
            r.move_position_um = snap_close;
            count = '0;
            phase = GPS_PHASE_CLOSE;
          end
        end
        default: begin
          bump_count();
          if (!close_seen && t.moving) begin
            close_seen = 1'b1;
            close_motion = count;
          end
          if (done || count > timeout_len) begin
            finished = 1'b1;
            close_reach = count;
            close_to = !done;
            count = '0;
            phase = GPS_PHASE_IDLE;
          end
        end
      endcase
      r.phase_now = phase;
      if (finished) begin
        r.report_valid = 1'b1;
        r.open_motion_seen = open_seen;
        r.open_motion_ticks = open_motion;
        r.open_reach_ticks = open_reach;
        r.open_timed_out = open_to;
        r.close_motion_seen = close_seen;
        r.close_motion_ticks = close_motion;
        r.close_reach_ticks = close_reach;
        r.close_timed_out = close_to;
      end
      expected_outcomes.push_back(r);
    endfunction

    task report_mismatch(string msg);
      if (fails < MAX_PRINTS) $display("[%0t] MISMATCH item %0d: %s", $time, outcomes_seen, msg);
      fails++;
    endtask

    task check_field(string name, logic [GPS_POS_W-1:0] got, logic [GPS_POS_W-1:0] want);
      if (got !== want) report_mismatch($sformatf("%s got %0d expected %0d", name, got, want));
    endtask

    task check_outcome(gps_result_t got);
      gps_result_t want;
      if (expected_outcomes.size() == 0) begin
        report_mismatch("result item with no tick outstanding");
        return;
      end
      want = expected_outcomes.pop_front();
      check_field("issue_move", got.issue_move, want.issue_move);
      check_field("move_position_um", got.move_position_um, want.move_position_um);
      check_field("phase_now", got.phase_now, want.phase_now);
      check_field("report_valid", got.report_valid, want.report_valid);
      check_field("open_motion_seen", got.open_motion_seen, want.open_motion_seen);
      check_field("open_motion_ticks", got.open_motion_ticks, want.open_motion_ticks);
      check_field("open_reach_ticks", got.open_reach_ticks, want.open_reach_ticks);
      check_field("open_timed_out", got.open_timed_out, want.open_timed_out);
      check_field("close_motion_seen", got.close_motion_seen, want.close_motion_seen);
      check_field("close_motion_ticks", got.close_motion_ticks, want.close_motion_ticks);
      check_field("close_reach_ticks", got.close_reach_ticks, want.close_reach_ticks);
      check_field("close_timed_out", got.close_timed_out, want.close_timed_out);
      outcomes_seen++;
    endtask
  endclass

  logic                     clk = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     cfg_we = 1'b0;
  logic [GPS_CFG_IDX_W-1:0] cfg_index = '0;
  logic [GPS_POS_W-1:0]     cfg_wdata = '0;
  logic                     in_valid = 1'b0;
  logic                     in_ready;
  logic                     in_trigger = 1'b0;
  logic                     in_moving = 1'b0;
  logic                     in_at_position = 1'b0;
  logic                     in_object_detected = 1'b0;
  logic                     out_valid;
  logic                     out_ready = 1'b0;
  logic                     out_issue_move;
  logic [GPS_POS_W-1:0]     out_move_position_um;
  logic [GPS_PHASE_W-1:0]   out_phase_now;
  logic                     out_report_valid;
  logic                     out_open_motion_seen;
  logic [GPS_TICKS_W-1:0]   out_open_motion_ticks;
  logic [GPS_TICKS_W-1:0]   out_open_reach_ticks;
  logic                     out_open_timed_out;
  logic                     out_close_motion_seen;
  logic [GPS_TICKS_W-1:0]   out_close_motion_ticks;
  logic [GPS_TICKS_W-1:0]   out_close_reach_ticks;
  logic                     out_close_timed_out;

  bit           idle_on = 1'b0;
  bit           long_stall_pending = 1'b0;
  pulse_tracker tracker = new();

  gripper_pulse_sequencer_core dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cfg_we               (cfg_we),
    .cfg_index            (cfg_index),
    .cfg_wdata            (cfg_wdata),
    .in_valid             (in_valid),
    .in_ready             (in_ready),
    .in_trigger           (in_trigger),
    .in_moving            (in_moving),
    .in_at_position       (in_at_position),
    .in_object_detected   (in_object_detected),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_issue_move       (out_issue_move),
    .out_move_position_um (out_move_position_um),
    .out_phase_now        (out_phase_now),
    .out_report_valid     (out_report_valid),
    .out_open_motion_seen (out_open_motion_seen),
    .out_open_motion_ticks(out_open_motion_ticks),
    .out_open_reach_ticks (out_open_reach_ticks),
    .out_open_timed_out   (out_open_timed_out),
    .out_close_motion_seen(out_close_motion_seen),
    .out_close_motion_ticks(out_close_motion_ticks),
    .out_close_reach_ticks(out_close_reach_ticks),
    .out_close_timed_out  (out_close_timed_out)
  );

  always begin
    #(CLK_PERIOD / 2) clk = 1'b1;
    #(CLK_PERIOD / 2) clk = 1'b0;
  end

  // valid is only dropped when a gap follows, so back-to-back items keep it high
  task automatic send_tick(input logic trig, input logic mov, input logic atp,
                           input logic obj);
    int        gap;
    gps_tick_t t;
    gap = idle_on ? $urandom_range(0, 11) : 0;
    t.trigger = trig;
    t.moving = mov;
    t.at_target = atp;
    t.obj_stop = obj;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_trigger <= trig;
    in_moving <= mov;
    in_at_position <= atp;
    in_object_detected <= obj;
    do @(posedge clk); while (!in_ready);
    tracker.advance_pulse(t);
  endtask

  task automatic drain();
    while (tracker.expected_outcomes.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [GPS_CFG_IDX_W-1:0] idx,
                           input logic [GPS_POS_W-1:0] data);
    in_valid <= 1'b0;
    drain();
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    tracker.write_reg(idx, data);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic load_config(input logic [GPS_POS_W-1:0] open_um,
                             input logic [GPS_POS_W-1:0] close_um,
                             input logic [GPS_POS_W-1:0] hold_len,
                             input logic [GPS_POS_W-1:0] timeout_len);
    write_reg(GPS_REG_OPEN_POS, open_um);
    write_reg(GPS_REG_CLOSE_POS, close_um);
    write_reg(GPS_REG_HOLD, hold_len);
    write_reg(GPS_REG_TIMEOUT, timeout_len);
    // unmapped index, must be dropped
    write_reg(GPS_CFG_IDX_W'($urandom_range(REG_UNUSED_FIRST, REG_UNUSED_LAST)),
              GPS_POS_W'($urandom));
  endtask

  task automatic run_random(input int n, input bit squeeze);
    logic trig, mov, atp, obj;
    for (int i = 0; i < n; i++) begin
      if (squeeze && i == n / 2) long_stall_pending = 1'b1;
      if ($urandom_range(0, 4) == 0) begin
        {trig, mov, atp, obj} = 4'($urandom);
      end else begin
        trig = ($urandom_range(0, 2) == 0);
        mov = ($urandom_range(0, 3) == 0);
        atp = ($urandom_range(0, 9) == 0);
        obj = ($urandom_range(0, 11) == 0);
      end
      send_tick(trig, mov, atp, obj);
    end
  endtask

  initial begin : result_sink
    gps_result_t got;
    int          stall;
    wait (rst_n === 1'b1);
    forever begin
      stall = idle_on ? $urandom_range(0, 11) : 0;
      if (long_stall_pending) begin
        stall = LONG_STALL;
        long_stall_pending = 1'b0;
      end
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      got.issue_move = out_issue_move;
      got.move_position_um = out_move_position_um;
      got.phase_now = out_phase_now;
      got.report_valid = out_report_valid;
      got.open_motion_seen = out_open_motion_seen;
      got.open_motion_ticks = out_open_motion_ticks;
      got.open_reach_ticks = out_open_reach_ticks;
      got.open_timed_out = out_open_timed_out;
      got.close_motion_seen = out_close_motion_seen;
      got.close_motion_ticks = out_close_motion_ticks;
      got.close_reach_ticks = out_close_reach_ticks;
      got.close_timed_out = out_close_timed_out;
      tracker.check_outcome(got);
    end
  end

  initial begin : stimulus
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: short waits so every phase ending shows up
    idle_on = 1'b1;
    load_config(POS_MAX, '0, GPS_POS_W'(2), GPS_POS_W'(3));
    send_tick(1'b0, 1'b1, 1'b1, 1'b1);
    send_tick(1'b1, 1'b1, 1'b1, 1'b1);
    send_tick(1'b1, 1'b1, 1'b0, 1'b0);
    send_tick(1'b0, 1'b0, 1'b1, 1'b0);
    send_tick(1'b1, 1'b0, 1'b0, 1'b0);
    send_tick(1'b0, 1'b0, 1'b0, 1'b0);
    repeat (4) send_tick(1'b0, 1'b0, 1'b0, 1'b0);
    send_tick(1'b1, 1'b0, 1'b0, 1'b0);
    repeat (4) send_tick(1'b0, 1'b0, 1'b0, 1'b0);
    send_tick(1'b0, 1'b0, 1'b0, 1'b0);
    // mid-pulse update: close target and hold keep their trigger values
    write_reg(GPS_REG_HOLD, '0);
    write_reg(GPS_REG_CLOSE_POS, POS_MAX);
    write_reg(GPS_REG_TIMEOUT, '0);
    write_reg(GPS_REG_OPEN_POS, '0);
    send_tick(1'b0, 1'b0, 1'b0, 1'b0);
    send_tick(1'b0, 1'b1, 1'b0, 1'b0);
    send_tick(1'b1, 1'b0, 1'b0, 1'b1);
    send_tick(1'b0, 1'b1, 1'b0, 1'b1);
    send_tick(1'b0, 1'b0, 1'b0, 1'b0);
    send_tick(1'b0, 1'b0, 1'b0, 1'b1);

    // long waits under a full-scale timeout: open ends on reach, close on object
    idle_on = 1'b0;
    load_config(POS_MAX, POS_MAX, GPS_POS_W'(LONG_HOLD), GPS_POS_W'(TICKS_MAX));
    send_tick(1'b1, 1'b0, 1'b0, 1'b0);
    repeat (LONG_HOLD) send_tick(1'b0, 1'b0, 1'b0, 1'b0);
    send_tick(1'b0, 1'b1, 1'b0, 1'b0);
    send_tick(1'b0, 1'b0, 1'b1, 1'b0);
    repeat (LONG_HOLD) send_tick(1'b0, 1'b0, 1'b0, 1'b0);
    send_tick(1'b0, 1'b1, 1'b0, 1'b0);
    send_tick(1'b0, 1'b0, 1'b0, 1'b1);

    for (int p = 0; p < 6; p++) begin
      case (p)
        1: load_config('0, POS_MAX, '0, '0);
        2: load_config(POS_MAX, '0, GPS_POS_W'(1), GPS_POS_W'(1));
        3: load_config(GPS_OPEN_POS_RST, GPS_CLOSE_POS_RST, GPS_POS_W'(GPS_HOLD_RST),
                       GPS_POS_W'(GPS_TIMEOUT_RST));
        default: load_config(GPS_POS_W'($urandom_range(0, POS_MAX)),
                             GPS_POS_W'($urandom_range(0, POS_MAX)),
                             {1'($urandom), 16'($urandom_range(0, 6))},
                             {1'($urandom), 16'($urandom_range(0, 12))});
      endcase
      idle_on = (p != 2);
      run_random(115, p == 3);
    end

    in_valid <= 1'b0;
    drain();
    repeat (4) @(posedge clk);
    if (tracker.fails == 0) begin
      $display("gripper_pulse_sequencer_core verification clean");
    end else begin
      $display("gripper_pulse_sequencer_core verification failed");
    end
    $finish;
  end

  initial begin : watchdog
    #(LIMIT_CYCLES * CLK_PERIOD);
    $display("gripper_pulse_sequencer_core verification failed");
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/gps_pkg.sv
rtl/gps_seq.sv
rtl/gripper_pulse_sequencer_core.sv
tb/sv/gripper_pulse_sequencer_core_test.sv
